### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// shared types and constants for the process tree table
// ----------------------------------------------------------------------------
`default_nettype none
package ptt_pkg;

  localparam int unsigned MaxSlotsDefault = 16;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusFull   = 2'd1;
  localparam logic [1:0] StatusRange  = 2'd2;

  localparam logic OpCreate  = 1'b0;
  localparam logic OpDestroy = 1'b1;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone    = 4'd0,
    CmdInit    = 4'd1,  // reset table entry at cursor
    CmdLoad    = 4'd2,  // latch request
    CmdScanAdv = 4'd3,  // advance create scan
    CmdLinkNew = 4'd4,  // write new slot, start chain at first child
    CmdChainAdv= 4'd5,  // follow younger sibling
    CmdAttach  = 4'd6,  // link new slot onto chain end or as first child
    CmdPushAdv = 4'd7,  // push one child of the node under walk
    CmdPop     = 4'd8,  // pop stack top, start pushing its children
    CmdFreeNode= 4'd9,  // clear popped node and count it
    CmdCfg     = 4'd10, // take new slot count
    CmdClrChild= 4'd11  // clear first child of the request process
  } cmd_e;

  typedef struct packed {
    logic init_done;
    logic idx_bad;
    logic scan_hit;
    logic scan_end;
    logic chain_end;
    logic push_end;
    logic stack_empty;
  } dp_status_t;

endpackage
`default_nettype wire

### src/process_tree_table_unit.sv
// ----------------------------------------------------------------------------
// process_tree_table_unit
// process slot tree with create and destroy requests
// ----------------------------------------------------------------------------
// steps to result: bad index after the check; table full after a scan of the
// slots in use; create scans slots before the free one, then older siblings
// destroy: per freed descendant a push, pop, child scan end and clear
// one request at a time; the next is taken the cycle after the result while
// out_stall_i holds no result; reset and every config write run a sweep
// that rebuilds the table; during the sweep no request is taken
`default_nettype none
`include "assert_macros.svh"
module process_tree_table_unit #(
  parameter int unsigned MaxSlots = ptt_pkg::MaxSlotsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // request channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       op_i,
  input  wire logic [3:0] process_index_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      status_o,
  output logic [3:0]      new_slot_o,
  output logic [3:0]      removed_count_o,
  // slot count register
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [4:0] cfg_data_i
);
  ptt_pkg::dp_status_t dp_status;
  ptt_pkg::cmd_e       cmd;
  ptt_pkg::cmd_e       cmd_dp;
  logic                done;
  logic [1:0]          ctl_status;
  logic                kill;
  logic                core_stall;
  logic                op_lat;
  logic [3:0]          dp_new_slot;
  logic [3:0]          dp_removed;

  // result register: block waits while a result is still held
  logic       out_valid_q;
  logic [1:0] status_q;
  logic [3:0] new_slot_q;
  logic [3:0] removed_q;
  logic       hold;

  assign hold       = out_valid_q && out_stall_i;
  assign in_stall_o = core_stall || hold;

  // kill marks the end of the request's own child push, the cycle in
  // which the controller clears its first child
  assign cmd_dp = cmd;

  ptt_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i && !hold),
    .in_stall_o  (core_stall),
    .op_i        (op_lat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .dp_i        (dp_status),
    .cmd_o       (cmd),
    .done_o      (done),
    .status_o    (ctl_status),
    .kill_o      (kill)
  );

  ptt_datapath #(.MaxSlots(MaxSlots)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_dp),
    .op_i            (op_i),
    .process_index_i (process_index_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (dp_status),
    .op_o            (op_lat),
    .new_slot_o      (dp_new_slot),
    .removed_count_o (dp_removed)
  );

  // kill pulse of the previous cycle, one clear per destroy
  logic kill_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kill_q <= 1'b0;
    else         kill_q <= kill;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q   <= ctl_status;
      new_slot_q <= (ctl_status == ptt_pkg::StatusOk && op_lat == ptt_pkg::OpCreate) ?
                    dp_new_slot : 4'd0;
      removed_q  <= (ctl_status == ptt_pkg::StatusOk && op_lat == ptt_pkg::OpDestroy) ?
                    dp_removed : 4'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign new_slot_o      = new_slot_q;
  assign removed_count_o = removed_q;

  `ASSERT_ALWAYS(a_no_drop, clk_i, rst_ni, !(done && hold), "result overwritten while held")
  `ASSERT_ALWAYS(a_cfg_idle, clk_i, rst_ni, !(cfg_ready_o && core_stall && !cfg_valid_i), "cfg ready while busy")
  `ASSERT_NEXT(a_done_valid, clk_i, rst_ni, done, out_valid_o, "done without result")
  `ASSERT_ALWAYS(a_kill_once, clk_i, rst_ni, !(kill && kill_q), "double first-child clear")
endmodule
`default_nettype wire

### src/ptt_datapath.sv
// ----------------------------------------------------------------------------
// ptt_datapath
// link tables, walk stack and counters of the process tree table
// ----------------------------------------------------------------------------
`default_nettype none
module ptt_datapath #(
  parameter int unsigned MaxSlots = ptt_pkg::MaxSlotsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptt_pkg::cmd_e     cmd_i,
  input  wire logic              op_i,
  input  wire logic [3:0]        process_index_i,
  input  wire logic [4:0]        cfg_data_i,
  output ptt_pkg::dp_status_t    status_o,
  output logic                   op_o,
  output logic [3:0]             new_slot_o,
  output logic [3:0]             removed_count_o
);
  localparam int unsigned IW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [IW:0] NoLink = {(IW+1){1'b1}};

  logic [IW:0] parent_q [MaxSlots];
  logic [IW:0] child_q  [MaxSlots];
  logic [IW:0] older_q  [MaxSlots];
  logic [IW:0] younger_q[MaxSlots];
  logic [IW-1:0] stack_q [MaxSlots];

  logic [CW-1:0] slots_q;
  logic [CW-1:0] cur_q;    // scan / init cursor
  logic [CW-1:0] top_q;    // stack fill
  logic [IW:0]   walk_q;   // link being followed
  logic [IW-1:0] node_q;   // popped node
  logic [IW-1:0] pidx_q;
  logic          idx_far_q; // index beyond slots in use
  logic [IW-1:0] new_q;
  logic [CW-1:0] guard_q;
  logic [4:0]    count_q;
  logic          op_q;

  logic [CW-1:0] top_dec;
  logic          walk_ok;

  assign top_dec = top_q - 1'b1;
  assign walk_ok = !walk_q[IW];

  always_comb begin
    status_o.init_done   = (cur_q == CW'(MaxSlots - 1));
    status_o.idx_bad     = idx_far_q || (parent_q[pidx_q] == NoLink);
    status_o.scan_end    = (cur_q >= slots_q);
    status_o.scan_hit    = !status_o.scan_end &&
                           (parent_q[cur_q[IW-1:0]] == NoLink);
    status_o.chain_end   = !walk_ok || younger_q[walk_q[IW-1:0]][IW] ||
                           (guard_q >= CW'(MaxSlots));
    status_o.push_end    = !walk_ok || (guard_q >= CW'(MaxSlots)) ||
                           (top_q >= CW'(MaxSlots));
    status_o.stack_empty = (top_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= CW'(MaxSlots);
      cur_q   <= '0;
      top_q   <= '0;
      count_q <= '0;
      op_q    <= 1'b0;
    end else begin
      case (cmd_i)
        ptt_pkg::CmdCfg: begin
          if (cfg_data_i == 5'd0) slots_q <= CW'(1);
          else if (32'(cfg_data_i) > MaxSlots) slots_q <= CW'(MaxSlots);
          else slots_q <= CW'(cfg_data_i);
          cur_q <= '0;
        end
        ptt_pkg::CmdInit: begin
          if (cur_q != CW'(MaxSlots - 1)) cur_q <= cur_q + 1'b1;
        end
        ptt_pkg::CmdLoad: begin
          cur_q   <= '0;
          top_q   <= '0;
          count_q <= '0;
          op_q    <= op_i;
        end
        ptt_pkg::CmdScanAdv: cur_q <= cur_q + 1'b1;
        ptt_pkg::CmdPushAdv: top_q <= top_q + 1'b1;
        ptt_pkg::CmdPop:     top_q <= top_dec;
        ptt_pkg::CmdFreeNode: if (count_q != 5'd31) count_q <= count_q + 1'b1;
        default: ;
      endcase
    end
  end

  // payload and tables, no reset: the init sweep writes the link tables
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      ptt_pkg::CmdCfg: ;
      ptt_pkg::CmdInit: begin
        parent_q [cur_q[IW-1:0]] <= (cur_q == '0) ? '0 : NoLink;
        child_q  [cur_q[IW-1:0]] <= NoLink;
        older_q  [cur_q[IW-1:0]] <= NoLink;
        younger_q[cur_q[IW-1:0]] <= NoLink;
      end
      ptt_pkg::CmdLoad: begin
        pidx_q    <= IW'(process_index_i);
        idx_far_q <= (32'(process_index_i) >= 32'(slots_q)) ||
                     (32'(process_index_i) >= MaxSlots);
        walk_q    <= child_q[IW'(process_index_i)];
        guard_q   <= '0;
      end
      ptt_pkg::CmdLinkNew: begin
        new_q <= cur_q[IW-1:0];
        parent_q [cur_q[IW-1:0]] <= {1'b0, pidx_q};
        child_q  [cur_q[IW-1:0]] <= NoLink;
        older_q  [cur_q[IW-1:0]] <= NoLink;
        younger_q[cur_q[IW-1:0]] <= NoLink;
        walk_q  <= child_q[pidx_q];
        guard_q <= '0;
      end
      ptt_pkg::CmdChainAdv: begin
        walk_q  <= younger_q[walk_q[IW-1:0]];
        guard_q <= guard_q + 1'b1;
      end
      ptt_pkg::CmdAttach: begin
        if (walk_ok) begin
          younger_q[walk_q[IW-1:0]] <= {1'b0, new_q};
          older_q[new_q] <= walk_q;
        end else begin
          child_q[pidx_q] <= {1'b0, new_q};
        end
      end
      ptt_pkg::CmdPushAdv: begin
        stack_q[top_q[IW-1:0]] <= walk_q[IW-1:0];
        walk_q  <= younger_q[walk_q[IW-1:0]];
        guard_q <= guard_q + 1'b1;
      end
      ptt_pkg::CmdPop: begin
        node_q  <= stack_q[top_dec[IW-1:0]];
        walk_q  <= child_q[stack_q[top_dec[IW-1:0]]];
        guard_q <= '0;
      end
      ptt_pkg::CmdFreeNode: begin
        parent_q [node_q] <= NoLink;
        child_q  [node_q] <= NoLink;
        older_q  [node_q] <= NoLink;
        younger_q[node_q] <= NoLink;
      end
      // children of the destroyed process are all pushed
      ptt_pkg::CmdClrChild: child_q[pidx_q] <= NoLink;
      default: ;
    endcase
  end

  assign op_o            = op_q;
  assign new_slot_o      = 4'(new_q);
  assign removed_count_o = (count_q > 5'd15) ? 4'd15 : count_q[3:0];
endmodule
`default_nettype wire

### src/ptt_controller.sv
// ----------------------------------------------------------------------------
// ptt_controller
// sequencer for create and destroy requests
// ----------------------------------------------------------------------------
`default_nettype none
module ptt_controller (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 op_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire ptt_pkg::dp_status_t  dp_i,
  output ptt_pkg::cmd_e             cmd_o,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic                      kill_o
);
  typedef enum logic [7:0] {
    StInit  = 8'b0000_0001,
    StIdle  = 8'b0000_0010,
    StCheck = 8'b0000_0100,
    StScan  = 8'b0000_1000,
    StChain = 8'b0001_0000,
    StPush  = 8'b0010_0000,
    StWalk  = 8'b0100_0000,
    StFree  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   root_q, root_d;   // still pushing children of the request process

  // a config write wins over a request in the same cycle
  assign in_stall_o  = (state_q != StIdle) || cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);

  always_comb begin
    state_d  = state_q;
    root_d   = root_q;
    cmd_o    = ptt_pkg::CmdNone;
    done_o   = 1'b0;
    status_o = ptt_pkg::StatusOk;
    kill_o   = 1'b0;
    case (state_q)
      StInit: begin
        cmd_o = ptt_pkg::CmdInit;
        if (dp_i.init_done) state_d = StIdle;
      end
      StIdle: begin
        if (cfg_valid_i) begin
          cmd_o   = ptt_pkg::CmdCfg;
          state_d = StInit;
        end else if (in_valid_i) begin
          cmd_o = ptt_pkg::CmdLoad;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (dp_i.idx_bad) begin
          done_o = 1'b1; status_o = ptt_pkg::StatusRange; state_d = StIdle;
        end else if (op_i == ptt_pkg::OpCreate) begin
          state_d = StScan;
        end else begin
          root_d = 1'b1; state_d = StPush;
        end
      end
      StScan: begin
        if (dp_i.scan_end) begin
          done_o = 1'b1; status_o = ptt_pkg::StatusFull; state_d = StIdle;
        end else if (dp_i.scan_hit) begin
          cmd_o = ptt_pkg::CmdLinkNew; state_d = StChain;
        end else begin
          cmd_o = ptt_pkg::CmdScanAdv;
        end
      end
      StChain: begin
        if (dp_i.chain_end) begin
          cmd_o = ptt_pkg::CmdAttach; done_o = 1'b1; state_d = StIdle;
        end else begin
          cmd_o = ptt_pkg::CmdChainAdv;
        end
      end
      StPush: begin
        if (dp_i.push_end) begin
          if (root_q) begin
            kill_o = 1'b1;
            cmd_o  = ptt_pkg::CmdClrChild;
          end
          root_d = 1'b0;
          state_d = root_q ? StWalk : StFree;
        end else begin
          cmd_o = ptt_pkg::CmdPushAdv;
        end
      end
      StFree: begin
        cmd_o = ptt_pkg::CmdFreeNode; state_d = StWalk;
      end
      StWalk: begin
        if (dp_i.stack_empty) begin
          done_o = 1'b1; state_d = StIdle;
        end else begin
          cmd_o = ptt_pkg::CmdPop; state_d = StPush;
        end
      end
      default: state_d = StInit;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      root_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
    end
  end
endmodule
`default_nettype wire
